/* sv/round_robin_slot_allocator_macros.svh */
// Assertion macros for the round-robin slot allocator.
`ifndef ROUND_ROBIN_SLOT_ALLOCATOR_MACROS_SVH
`define ROUND_ROBIN_SLOT_ALLOCATOR_MACROS_SVH

// Same-cycle implication, sampled on clk, off while reset is low.
`define RRSA_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rrsa assertion failed");

// Next-cycle implication, sampled on clk, off while reset is low.
`define RRSA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rrsa assertion failed");

`endif

/* sv/rrsa_pkg.sv */
// Shared types and constants of the round-robin slot allocator.
package rrsa_pkg;

    localparam int SLOT_W = 6;
    localparam int CNT_W  = 7;

    localparam logic [1:0] MODE_GET     = 2'd0;
    localparam logic [1:0] MODE_DEACT   = 2'd1;
    localparam logic [1:0] MODE_DESTROY = 2'd2;

    localparam logic [CNT_W-1:0] SLOT_COUNT_RESET = 7'd64;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_COMMIT,
        ST_REPLY
    } state_t;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_GRANT_NEW,
        OP_GRANT_EVICT,
        OP_DEACT,
        OP_DESTROY
    } op_t;

    typedef struct packed {
        op_t              op;
        logic [SLOT_W-1:0] idx;
    } tbl_cmd_t;

    typedef struct packed {
        logic used;
        logic active;
    } slot_bits_t;

    typedef struct packed {
        logic [SLOT_W-1:0] granted;
        logic              evicted;
        logic              full;
    } reply_t;

endpackage

/* sv/rrsa_slot_table.sv */
// Per-slot used and active flags with their population counts.
module rrsa_slot_table #(
    parameter int CAP = 64
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic [rrsa_pkg::SLOT_W-1:0]  rd_addr,
    output rrsa_pkg::slot_bits_t         rd_bits,
    input  rrsa_pkg::tbl_cmd_t           cmd,
    output logic [rrsa_pkg::CNT_W-1:0]   active_total,
    output logic [rrsa_pkg::CNT_W-1:0]   used_total
);

    localparam int IDX_W = $clog2(CAP);

    logic [CAP-1:0]              used_reg, used_next;
    logic [CAP-1:0]              active_reg, active_next;
    logic [rrsa_pkg::CNT_W-1:0]  act_tot_reg, act_tot_next;
    logic [rrsa_pkg::CNT_W-1:0]  use_tot_reg, use_tot_next;
    logic [IDX_W-1:0]            ra;
    logic [IDX_W-1:0]            wa;

    assign ra = rd_addr[IDX_W-1:0];
    assign wa = cmd.idx[IDX_W-1:0];

    assign rd_bits.used   = used_reg[ra];
    assign rd_bits.active = active_reg[ra];

    always_comb begin
        used_next    = used_reg;
        active_next  = active_reg;
        act_tot_next = act_tot_reg;
        use_tot_next = use_tot_reg;
        case (cmd.op)
            rrsa_pkg::OP_GRANT_NEW: begin
                used_next[wa] = 1'b1;
                use_tot_next  = use_tot_reg + 7'd1;
                if (!active_reg[wa]) begin
                    active_next[wa] = 1'b1;
                    act_tot_next    = act_tot_reg + 7'd1;
                end
            end
            rrsa_pkg::OP_GRANT_EVICT: begin
                active_next[wa] = 1'b1;
                act_tot_next    = act_tot_reg + 7'd1;
            end
            rrsa_pkg::OP_DEACT, rrsa_pkg::OP_DESTROY: begin
                if (active_reg[wa]) begin
                    active_next[wa] = 1'b0;
                    act_tot_next    = act_tot_reg - 7'd1;
                end
                if (cmd.op == rrsa_pkg::OP_DESTROY && used_reg[wa]) begin
                    used_next[wa] = 1'b0;
                    use_tot_next  = use_tot_reg - 7'd1;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            used_reg    <= '0;
            active_reg  <= '0;
            act_tot_reg <= '0;
            use_tot_reg <= '0;
        end else begin
            used_reg    <= used_next;
            active_reg  <= active_next;
            act_tot_reg <= act_tot_next;
            use_tot_reg <= use_tot_next;
        end
    end

    assign active_total = act_tot_reg;
    assign used_total   = use_tot_reg;

endmodule

/* sv/rrsa_ctrl.sv */
// Sequencer: one slot examined per cycle from the rotating pointer, then commit.
module rrsa_ctrl (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [1:0]                   in_mode,
    input  logic [rrsa_pkg::SLOT_W-1:0]  in_index,
    input  logic [rrsa_pkg::CNT_W-1:0]   pool_n,
    output logic [rrsa_pkg::SLOT_W-1:0]  rd_addr,
    input  rrsa_pkg::slot_bits_t         rd_bits,
    output rrsa_pkg::tbl_cmd_t           cmd,
    output logic                         reply_valid,
    input  logic                         reply_ready,
    output rrsa_pkg::reply_t             reply
);

    rrsa_pkg::state_t            state_reg, state_next;
    logic [1:0]                  mode_reg, mode_next;
    logic [rrsa_pkg::SLOT_W-1:0] idx_reg, idx_next;
    logic [rrsa_pkg::CNT_W-1:0]  n_reg, n_next;
    logic [rrsa_pkg::SLOT_W-1:0] pos_reg, pos_next;
    logic [rrsa_pkg::CNT_W-1:0]  cnt_reg, cnt_next;
    logic [rrsa_pkg::SLOT_W-1:0] ptr_reg, ptr_next;
    logic                        hit_new_reg, hit_new_next;
    logic                        hit_old_reg, hit_old_next;
    logic [rrsa_pkg::SLOT_W-1:0] pick_reg, pick_next;
    logic [rrsa_pkg::SLOT_W-1:0] old_reg, old_next;
    rrsa_pkg::reply_t            reply_reg, reply_next;

    logic                        accept;
    logic                        is_get;
    logic                        last_slot;
    logic                        in_range;
    logic [rrsa_pkg::SLOT_W-1:0] pos_wrap;
    logic [rrsa_pkg::SLOT_W-1:0] win;
    logic [rrsa_pkg::SLOT_W-1:0] win_wrap;

    assign accept    = in_valid && in_ready;
    assign is_get    = (in_mode == rrsa_pkg::MODE_GET);
    assign last_slot = ((cnt_reg + 7'd1) == n_reg);
    assign in_range  = ({1'b0, idx_reg} < n_reg);
    assign pos_wrap  = (({1'b0, pos_reg} + 7'd1) == n_reg) ? '0 : pos_reg + 6'd1;
    assign win       = hit_new_reg ? pick_reg : old_reg;
    assign win_wrap  = (({1'b0, win} + 7'd1) == n_reg) ? '0 : win + 6'd1;

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            rrsa_pkg::ST_IDLE: begin
                if (accept) begin
                    state_next = is_get ? rrsa_pkg::ST_SCAN : rrsa_pkg::ST_COMMIT;
                end
            end
            rrsa_pkg::ST_SCAN: begin
                if (!rd_bits.used || last_slot) begin
                    state_next = rrsa_pkg::ST_COMMIT;
                end
            end
            rrsa_pkg::ST_COMMIT: state_next = rrsa_pkg::ST_REPLY;
            rrsa_pkg::ST_REPLY: begin
                if (reply_ready) begin
                    state_next = rrsa_pkg::ST_IDLE;
                end
            end
            default: state_next = rrsa_pkg::ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        in_ready    = 1'b0;
        reply_valid = 1'b0;
        rd_addr     = pos_reg;
        cmd.op      = rrsa_pkg::OP_NONE;
        cmd.idx     = win;
        case (state_reg)
            rrsa_pkg::ST_IDLE: in_ready = 1'b1;
            rrsa_pkg::ST_SCAN: rd_addr = pos_reg;
            rrsa_pkg::ST_COMMIT: begin
                if (mode_reg == rrsa_pkg::MODE_GET) begin
                    if (hit_new_reg) begin
                        cmd.op = rrsa_pkg::OP_GRANT_NEW;
                    end else if (hit_old_reg) begin
                        cmd.op = rrsa_pkg::OP_GRANT_EVICT;
                    end
                end else if (in_range) begin
                    cmd.idx = idx_reg;
                    if (mode_reg == rrsa_pkg::MODE_DEACT) begin
                        cmd.op = rrsa_pkg::OP_DEACT;
                    end else if (mode_reg == rrsa_pkg::MODE_DESTROY) begin
                        cmd.op = rrsa_pkg::OP_DESTROY;
                    end
                end
            end
            rrsa_pkg::ST_REPLY: reply_valid = 1'b1;
            default: begin
            end
        endcase
    end

    // datapath
    always_comb begin
        mode_next    = mode_reg;
        idx_next     = idx_reg;
        n_next       = n_reg;
        pos_next     = pos_reg;
        cnt_next     = cnt_reg;
        ptr_next     = ptr_reg;
        hit_new_next = hit_new_reg;
        hit_old_next = hit_old_reg;
        pick_next    = pick_reg;
        old_next     = old_reg;
        reply_next   = reply_reg;
        case (state_reg)
            rrsa_pkg::ST_IDLE: begin
                if (accept) begin
                    mode_next    = in_mode;
                    idx_next     = in_index;
                    n_next       = pool_n;
                    pos_next     = ({1'b0, ptr_reg} < pool_n) ? ptr_reg : '0;
                    cnt_next     = '0;
                    hit_new_next = 1'b0;
                    hit_old_next = 1'b0;
                    reply_next   = '0;
                end
            end
            rrsa_pkg::ST_SCAN: begin
                if (!rd_bits.used) begin
                    hit_new_next = 1'b1;
                    pick_next    = pos_reg;
                end else begin
                    if (!rd_bits.active && !hit_old_reg) begin
                        hit_old_next = 1'b1;
                        old_next     = pos_reg;
                    end
                    pos_next = pos_wrap;
                    cnt_next = cnt_reg + 7'd1;
                end
            end
            rrsa_pkg::ST_COMMIT: begin
                if (mode_reg == rrsa_pkg::MODE_GET) begin
                    if (hit_new_reg || hit_old_reg) begin
                        reply_next.granted = win;
                        reply_next.evicted = !hit_new_reg;
                        ptr_next           = win_wrap;
                    end else begin
                        reply_next.full = 1'b1;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= rrsa_pkg::ST_IDLE;
            ptr_reg   <= '0;
        end else begin
            state_reg <= state_next;
            ptr_reg   <= ptr_next;
        end
    end

    always_ff @(posedge aclk) begin
        mode_reg    <= mode_next;
        idx_reg     <= idx_next;
        n_reg       <= n_next;
        pos_reg     <= pos_next;
        cnt_reg     <= cnt_next;
        hit_new_reg <= hit_new_next;
        hit_old_reg <= hit_old_next;
        pick_reg    <= pick_next;
        old_reg     <= old_next;
        reply_reg   <= reply_next;
    end

    assign reply = reply_reg;

endmodule

/* sv/round_robin_slot_allocator.sv */
// Top level of the round-robin slot allocator: config register, table and sequencer.
// Usage:
//   s_valid/s_ready carry one request beat: s_mode (get, deactivate, destroy)
//   and s_slot_index. m_valid/m_ready return one result beat per request
//   with the granted slot, eviction and pool-full flags, and both counts.
//   cfg_valid/cfg_ready writes slot_count (pool size, wraps the search);
//   write it only while no request is outstanding. cfg_ready is always high.
// Sequence:
//   A get examines one slot per cycle from the rotating pointer through the
//   slot table read port, stopping at the first never-used slot or after all n
//   slots of the pool, then commits and returns its result. Deactivate and
//   destroy skip the scan and go straight to commit and result.
//   One request is in flight at a time; s_ready is low from accept until the
//   result beat is taken.
// Reset: all slot flags, counts and the pointer clear; slot_count becomes 64.
// Stall: while m_ready is low the result is held and no request is taken.
module round_robin_slot_allocator #(
    parameter int MAX_SLOTS = 64
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [1:0]                   s_mode,
    input  logic [rrsa_pkg::SLOT_W-1:0]  s_slot_index,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [rrsa_pkg::SLOT_W-1:0]  m_granted_slot,
    output logic                         m_evicted,
    output logic                         m_full_res,
    output logic [rrsa_pkg::CNT_W-1:0]   m_active_count,
    output logic [rrsa_pkg::CNT_W-1:0]   m_used_count,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [rrsa_pkg::CNT_W-1:0]   cfg_data
);

    `include "round_robin_slot_allocator_macros.svh"

    localparam int CAP = (MAX_SLOTS < 64) ? MAX_SLOTS : 64;
    localparam logic [rrsa_pkg::CNT_W-1:0] CAP_N = rrsa_pkg::CNT_W'(CAP);

    logic [rrsa_pkg::CNT_W-1:0]  slot_count_reg;
    logic [rrsa_pkg::CNT_W-1:0]  pool_n;
    logic [rrsa_pkg::SLOT_W-1:0] rd_addr;
    rrsa_pkg::slot_bits_t        rd_bits;
    rrsa_pkg::tbl_cmd_t          cmd;
    rrsa_pkg::reply_t            reply;
    logic [rrsa_pkg::CNT_W-1:0]  active_total;
    logic [rrsa_pkg::CNT_W-1:0]  used_total;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slot_count_reg <= rrsa_pkg::SLOT_COUNT_RESET;
        end else if (cfg_valid) begin
            slot_count_reg <= cfg_data;
        end
    end

    always_comb begin
        pool_n = slot_count_reg;
        if (slot_count_reg == '0) begin
            pool_n = 7'd1;
        end else if (slot_count_reg > CAP_N) begin
            pool_n = CAP_N;
        end
    end

    rrsa_slot_table #(
        .CAP(CAP)
    ) u_table (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .rd_addr      (rd_addr),
        .rd_bits      (rd_bits),
        .cmd          (cmd),
        .active_total (active_total),
        .used_total   (used_total)
    );

    rrsa_ctrl u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (s_valid),
        .in_ready    (s_ready),
        .in_mode     (s_mode),
        .in_index    (s_slot_index),
        .pool_n      (pool_n),
        .rd_addr     (rd_addr),
        .rd_bits     (rd_bits),
        .cmd         (cmd),
        .reply_valid (m_valid),
        .reply_ready (m_ready),
        .reply       (reply)
    );

    assign m_granted_slot = reply.granted;
    assign m_evicted      = reply.evicted;
    assign m_full_res     = reply.full;
    assign m_active_count = active_total;
    assign m_used_count   = used_total;

    `RRSA_ASSERT_SAME(a_full_grants_nothing, aclk, aresetn, m_valid && m_full_res,
        m_granted_slot == '0 && !m_evicted)
    `RRSA_ASSERT_SAME(a_active_le_used, aclk, aresetn, 1'b1,
        active_total <= used_total)
    `RRSA_ASSERT_NEXT(a_one_in_flight, aclk, aresetn, s_valid && s_ready,
        !s_ready)
    `RRSA_ASSERT_SAME(a_no_overlap, aclk, aresetn, m_valid, !s_ready)

endmodule
